FILE: hdl/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg
// Types and codes shared by the packet checksum and source filter.
// ----------------------------------------------------------------------------
package pcsf_pkg;

    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int VERDICT_W   = 3;
    localparam int NUM_RANGES  = 4;
    localparam int NUM_BOUNDS  = 2 * NUM_RANGES;
    localparam int CFG_ADDR_W  = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [VERDICT_W-1:0] VERDICT_HIGH         = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_MEDIUM       = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_LOW          = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN      = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_SOURCE   = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_CHECKSUM = 3'd5;

    localparam logic [1:0] TYPE_HIGH    = 2'd0;
    localparam logic [1:0] TYPE_MEDIUM  = 2'd1;
    localparam logic [1:0] TYPE_LOW     = 2'd2;
    localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

    localparam logic [HALF_W-1:0] SUM_GOOD = 16'hffff;

    typedef logic [NUM_BOUNDS-1:0][WORD_W-1:0] bounds_t;

    typedef struct packed {
        logic [WORD_W-1:0] source;
        logic [WORD_W-1:0] destination;
        logic [1:0]        type_code;
        logic              sum_ok;
    } pcsf_entry_t;

endpackage

FILE: hdl/pcsf_front.sv
// ----------------------------------------------------------------------------
// pcsf_front
// Takes packet words, keeps the folded ones' complement sum and the header
// words, and pushes one classified entry per packet.
// ----------------------------------------------------------------------------
module pcsf_front
    import pcsf_pkg::*;
#(
    parameter int PACKET_WORDS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_packet_word,
    output logic              push,
    output pcsf_entry_t       push_entry,
    input  logic              queue_full
);

    localparam int POS_W = $clog2(PACKET_WORDS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_WORDS - 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [HALF_W-1:0] sum_reg, sum_next;
    logic [WORD_W-1:0] source_reg, destination_reg;
    logic [1:0]        type_reg;
    logic              last_word;
    logic              take;
    logic [HALF_W+1:0] sum_wide;
    logic [HALF_W:0]   sum_fold1;
    logic [HALF_W-1:0] sum_fold2;

    assign last_word = (pos_reg == LAST_POS);
    assign s_ready   = !last_word || !queue_full;
    assign take      = s_valid && s_ready;

    assign sum_wide  = {2'b00, sum_reg} + {2'b00, s_packet_word[HALF_W-1:0]}
                     + {2'b00, s_packet_word[WORD_W-1:HALF_W]};
    assign sum_fold1 = {1'b0, sum_wide[HALF_W-1:0]} + {{(HALF_W-1){1'b0}}, sum_wide[HALF_W+1:HALF_W]};
    assign sum_fold2 = sum_fold1[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, sum_fold1[HALF_W]};

    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (take) begin
            if (last_word) begin
                pos_next = '0;
                sum_next = '0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                sum_next = sum_fold2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sum_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            if (pos_reg == POS_W'(0)) begin
                source_reg <= s_packet_word;
            end
            if (pos_reg == POS_W'(1)) begin
                destination_reg <= s_packet_word;
            end
            if (pos_reg == POS_W'(2)) begin
                if (s_packet_word > WORD_W'(2)) begin
                    type_reg <= TYPE_UNKNOWN;
                end else begin
                    type_reg <= s_packet_word[1:0];
                end
            end
        end
    end

    assign push                   = take && last_word;
    assign push_entry.source      = source_reg;
    assign push_entry.destination = destination_reg;
    assign push_entry.type_code   = type_reg;
    assign push_entry.sum_ok      = (sum_fold2 == SUM_GOOD);

endmodule

FILE: hdl/pcsf_queue.sv
// ----------------------------------------------------------------------------
// pcsf_queue
// Short queue of finished-packet entries between the front and back parts.
// ----------------------------------------------------------------------------
module pcsf_queue
    import pcsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  pcsf_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output pcsf_entry_t head
);

    pcsf_entry_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/pcsf_back.sv
// ----------------------------------------------------------------------------
// pcsf_back
// Pops entries, tests the source against the reject ranges, gives the
// verdict and advances the reject counters.
// ----------------------------------------------------------------------------
module pcsf_back
    import pcsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bounds_t              bounds,
    input  logic                 not_empty,
    input  pcsf_entry_t          head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VERDICT_W-1:0] m_verdict,
    output logic [WORD_W-1:0]    m_destination,
    output logic [WORD_W-1:0]    m_source_rejects,
    output logic [WORD_W-1:0]    m_checksum_rejects,
    output logic [WORD_W-1:0]    m_high_rejects,
    output logic [WORD_W-1:0]    m_medium_rejects,
    output logic [WORD_W-1:0]    m_low_rejects
);

    logic                 valid_reg;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [WORD_W-1:0]    destination_reg;
    logic [WORD_W-1:0]    src_cnt_reg, src_cnt_next;
    logic [WORD_W-1:0]    csum_cnt_reg, csum_cnt_next;
    logic [WORD_W-1:0]    type_cnt_reg [3];
    logic [WORD_W-1:0]    type_cnt_next [3];
    logic [NUM_RANGES-1:0] in_range;
    logic                 src_bad, csum_bad;

    assign pop = not_empty && (!valid_reg || m_ready);

    always_comb begin
        for (int r = 0; r < NUM_RANGES; r++) begin
            in_range[r] = (head.source > bounds[2*r]) && (head.source < bounds[2*r+1]);
        end
    end

    assign src_bad  = |in_range;
    assign csum_bad = !src_bad && !head.sum_ok;

    always_comb begin
        src_cnt_next  = src_cnt_reg + {{(WORD_W-1){1'b0}}, src_bad};
        csum_cnt_next = csum_cnt_reg + {{(WORD_W-1){1'b0}}, csum_bad};
        for (int t = 0; t < 3; t++) begin
            type_cnt_next[t] = type_cnt_reg[t];
            if ((src_bad || csum_bad) && (head.type_code == 2'(t))) begin
                type_cnt_next[t] = type_cnt_reg[t] + WORD_W'(1);
            end
        end
        if (src_bad) begin
            verdict_next = VERDICT_BAD_SOURCE;
        end else if (csum_bad) begin
            verdict_next = VERDICT_BAD_CHECKSUM;
        end else begin
            verdict_next = {1'b0, head.type_code};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            src_cnt_reg  <= '0;
            csum_cnt_reg <= '0;
            for (int t = 0; t < 3; t++) begin
                type_cnt_reg[t] <= '0;
            end
        end else begin
            if (pop) begin
                valid_reg    <= 1'b1;
                src_cnt_reg  <= src_cnt_next;
                csum_cnt_reg <= csum_cnt_next;
                for (int t = 0; t < 3; t++) begin
                    type_cnt_reg[t] <= type_cnt_next[t];
                end
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            verdict_reg     <= verdict_next;
            destination_reg <= head.destination;
        end
    end

    assign m_valid            = valid_reg;
    assign m_verdict          = verdict_reg;
    assign m_destination      = destination_reg;
    assign m_source_rejects   = src_cnt_reg;
    assign m_checksum_rejects = csum_cnt_reg;
    assign m_high_rejects     = type_cnt_reg[0];
    assign m_medium_rejects   = type_cnt_reg[1];
    assign m_low_rejects      = type_cnt_reg[2];

    a_counters_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(src_cnt_reg) && $stable(csum_cnt_reg))
        else $error("reject counter moved without a pop");

    a_one_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !(src_bad && csum_bad))
        else $error("packet counted for two reject reasons");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (verdict_reg <= VERDICT_BAD_CHECKSUM))
        else $error("verdict code out of range");

endmodule

FILE: hdl/packet_checksum_source_filter.sv
// ----------------------------------------------------------------------------
// packet_checksum_source_filter
// Packet checksum and source-range filter with APB register port.
//
// Input channel s_*: one 32-bit packet word per handshake, PACKET_WORDS words
// per packet (source, destination, type, checksum, payload). Words are taken
// one per cycle; the only stall on s_ready is the last word of a packet
// while the two-entry queue is full. Result channel m_*: one result per
// packet, registered, valid once the entry has passed the queue and the
// result register. A result is held until m_ready; the queue keeps the
// input side running for up to two more packets meanwhile. Sustained rate:
// one word per cycle while results are taken. Registers: eight 32-bit range
// bounds at byte addresses 0x00..0x1C, written through the APB port while
// no packet is in flight, a user rule the block does not enforce; pready is
// always high. Reset (aresetn low, synchronous): word position, sum, queue
// and counters clear, all bounds go to zero (every range empty).
// ----------------------------------------------------------------------------
module packet_checksum_source_filter
    import pcsf_pkg::*;
#(
    parameter int PACKET_WORDS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_W-1:0]     s_packet_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VERDICT_W-1:0]  m_verdict,
    output logic [WORD_W-1:0]     m_destination,
    output logic [WORD_W-1:0]     m_source_rejects,
    output logic [WORD_W-1:0]     m_checksum_rejects,
    output logic [WORD_W-1:0]     m_high_rejects,
    output logic [WORD_W-1:0]     m_medium_rejects,
    output logic [WORD_W-1:0]     m_low_rejects
);

    bounds_t     bounds_reg;
    logic [2:0]  reg_index;
    logic        push, pop, queue_full, not_empty;
    pcsf_entry_t push_entry, head;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign prdata    = bounds_reg[reg_index];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            bounds_reg[reg_index] <= pwdata;
        end
    end

    pcsf_front #(
        .PACKET_WORDS(PACKET_WORDS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_packet_word(s_packet_word),
        .push         (push),
        .push_entry   (push_entry),
        .queue_full   (queue_full)
    );

    pcsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    pcsf_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .bounds            (bounds_reg),
        .not_empty         (not_empty),
        .head              (head),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_destination     (m_destination),
        .m_source_rejects  (m_source_rejects),
        .m_checksum_rejects(m_checksum_rejects),
        .m_high_rejects    (m_high_rejects),
        .m_medium_rejects  (m_medium_rejects),
        .m_low_rejects     (m_low_rejects)
    );

endmodule
